### design/double_cosine_poly_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double cosine polynomial block
// Shorthand for clocked checks that use clk and arst_n of the module that
// includes this header.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_COSINE_POLY_TOP_DEFINES_SVH
`define DOUBLE_COSINE_POLY_TOP_DEFINES_SVH

// Check that holds in the same cycle as its condition.
`define DCP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that holds in the cycle after its condition.
`define DCP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/dcp_pkg.sv
// ----------------------------------------------------------------------------
// dcp_pkg
// Types, constants and the operation schedule of the cosine pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcp_pkg;

	localparam int NOPS   = 29;
	localparam int OP_LAT = 4;

	localparam logic [63:0] MAG_MASK   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIMIT_BITS = 64'h4160_0000_0000_0000;

	localparam logic [63:0] K_INV_PI = 64'h3FD4_5F30_6DC9_C883;
	localparam logic [63:0] K_HALF   = 64'h3FE0_0000_0000_0000;
	localparam logic [63:0] K_NHALF  = 64'hBFE0_0000_0000_0000;
	localparam logic [63:0] K_SHIFT  = 64'h4338_0000_0000_0000;
	localparam logic [63:0] K_NSHIFT = 64'hC338_0000_0000_0000;
	localparam logic [63:0] K_PI_HI  = 64'hC009_21FB_5444_2D18;
	localparam logic [63:0] K_PI_MID = 64'hBCA1_A626_3314_5C07;
	localparam logic [63:0] K_PI_LO  = 64'h392F_1976_B7ED_8FBC;
	localparam logic [63:0] K_C0     = 64'hBFC5_5555_5555_5555;
	localparam logic [63:0] K_C1     = 64'h3F81_1111_1111_10B0;
	localparam logic [63:0] K_C2     = 64'hBF2A_01A0_1A01_3E1A;
	localparam logic [63:0] K_C3     = 64'h3EC7_1DE3_A524_F063;
	localparam logic [63:0] K_C4     = 64'hBE5A_E645_4B5D_C0B5;
	localparam logic [63:0] K_C5     = 64'h3DE6_123C_686A_D6B4;
	localparam logic [63:0] K_C6     = 64'hBD6A_E420_DC08_FD52;
	localparam logic [63:0] K_C7     = 64'h3CE8_80FF_69A8_3BBE;

	typedef enum logic {FOP_MUL, FOP_ADD} fop_t;

	typedef enum logic [2:0] {
		SRC_AX, SRC_ACC, SRC_K, SRC_F, SRC_F2, SRC_F3, SRC_CONST
	} src_t;

	typedef enum logic [2:0] {DST_ACC, DST_K, DST_F, DST_F2, DST_F3} dst_t;

	typedef struct packed {
		fop_t        kind;
		src_t        sa;
		src_t        sb;
		dst_t        dst;
		logic        kcap;
		logic [63:0] cval;
	} op_desc_t;

	// Values that travel down the pipeline next to the arithmetic.
	typedef struct packed {
		logic        oor;
		logic        kbit;
		logic [63:0] ax;
		logic [63:0] k;
		logic [63:0] f;
		logic [63:0] f2;
		logic [63:0] f3;
		logic [63:0] acc;
	} carry_t;

	typedef struct packed {
		logic [63:0] cos;
		logic        oor;
	} result_t;

	// Schedule: one floating point operation per slot, in program order.
	function automatic op_desc_t op_desc(input int idx);
		op_desc_t d;
		d = '{kind: FOP_ADD, sa: SRC_ACC, sb: SRC_CONST, dst: DST_ACC, kcap: 1'b0,
			cval: 64'h0};
		case (idx)
			0: begin
				d.kind = FOP_MUL; d.sa = SRC_AX; d.cval = K_INV_PI;
			end
			1: d.cval = K_HALF;
			2: begin
				d.cval = K_SHIFT; d.kcap = 1'b1;
			end
			3: d.cval = K_NSHIFT;
			4: begin
				d.cval = K_NHALF; d.dst = DST_K;
			end
			5: begin
				d.kind = FOP_MUL; d.sa = SRC_K; d.cval = K_PI_HI;
			end
			6: begin
				d.sa = SRC_AX; d.sb = SRC_ACC; d.dst = DST_F;
			end
			7: begin
				d.kind = FOP_MUL; d.sa = SRC_K; d.cval = K_PI_MID;
			end
			8, 10: begin
				d.sa = SRC_F; d.sb = SRC_ACC; d.dst = DST_F;
			end
			9: begin
				d.kind = FOP_MUL; d.sa = SRC_K; d.cval = K_PI_LO;
			end
			11: begin
				d.kind = FOP_MUL; d.sa = SRC_F; d.sb = SRC_F; d.dst = DST_F2;
			end
			12: begin
				d.kind = FOP_MUL; d.sa = SRC_F2; d.sb = SRC_F; d.dst = DST_F3;
			end
			13: begin
				d.kind = FOP_MUL; d.sa = SRC_F2; d.cval = K_C7;
			end
			14: d.cval = K_C6;
			16: d.cval = K_C5;
			18: d.cval = K_C4;
			20: d.cval = K_C3;
			22: d.cval = K_C2;
			24: d.cval = K_C1;
			26: d.cval = K_C0;
			15, 17, 19, 21, 23, 25: begin
				d.kind = FOP_MUL; d.sb = SRC_F2;
			end
			27: begin
				d.kind = FOP_MUL; d.sb = SRC_F3;
			end
			28: begin
				d.sa = SRC_F; d.sb = SRC_ACC;
			end
			default: d.cval = 64'h0;
		endcase
		return d;
	endfunction

	function automatic logic [63:0] pick(input carry_t c, input src_t s,
		input logic [63:0] cv);
		logic [63:0] v;
		unique case (s)
			SRC_AX:  v = c.ax;
			SRC_ACC: v = c.acc;
			SRC_K:   v = c.k;
			SRC_F:   v = c.f;
			SRC_F2:  v = c.f2;
			SRC_F3:  v = c.f3;
			default: v = cv;
		endcase
		return v;
	endfunction

	function automatic carry_t put(input carry_t c, input op_desc_t d,
		input logic [63:0] y);
		carry_t r;
		r = c;
		unique case (d.dst)
			DST_K:   r.k = y;
			DST_F:   r.f = y;
			DST_F2:  r.f2 = y;
			DST_F3:  r.f3 = y;
			default: r.acc = y;
		endcase
		if (d.kcap) begin
			r.kbit = y[0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### design/dcp_fop.sv
// ----------------------------------------------------------------------------
// dcp_fop
// Four-stage IEEE double multiply or add with round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcp_fop (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  dcp_pkg::fop_t     kind,
	input  logic              in_vld,
	input  dcp_pkg::carry_t   in_carry,
	input  logic [63:0]       a,
	input  logic [63:0]       b,
	output logic              out_vld,
	output dcp_pkg::carry_t   out_carry,
	output logic [63:0]       y
);
	import dcp_pkg::*;

	// Stage 1: unpack, partial products, operand ordering.
	logic [10:0] ea, eb, xa, xb, xbig, xsm, dd;
	logic [52:0] ma, mb;
	logic        swap;
	logic [63:0] big, sml;
	logic [51:0] pp11;
	logic [52:0] pp10, pp01;
	logic [53:0] pp00;
	logic signed [13:0] mx;

	assign ea   = a[62:52];
	assign eb   = b[62:52];
	assign ma   = {ea != 11'd0, a[51:0]};
	assign mb   = {eb != 11'd0, b[51:0]};
	assign xa   = (ea == 11'd0) ? 11'd1 : ea;
	assign xb   = (eb == 11'd0) ? 11'd1 : eb;
	assign pp11 = 52'(ma[52:27]) * 52'(mb[52:27]);
	assign pp10 = 53'(ma[52:27]) * 53'(mb[26:0]);
	assign pp01 = 53'(ma[26:0]) * 53'(mb[52:27]);
	assign pp00 = 54'(ma[26:0]) * 54'(mb[26:0]);
	assign mx   = $signed(14'(xa)) + $signed(14'(xb)) - 14'sd2150;
	assign swap = b[62:0] > a[62:0];
	assign big  = swap ? b : a;
	assign sml  = swap ? a : b;
	assign xbig = (big[62:52] == 11'd0) ? 11'd1 : big[62:52];
	assign xsm  = (sml[62:52] == 11'd0) ? 11'd1 : sml[62:52];
	assign dd   = xbig - xsm;

	logic               vld_s1;
	carry_t             carry_s1;
	logic               msgn_s1, asb_s1, ass_s1;
	logic signed [13:0] mx_s1;
	logic [51:0]        pp11_s1;
	logic [52:0]        pp10_s1, pp01_s1;
	logic [53:0]        pp00_s1;
	logic [52:0]        mbig_s1, msm_s1;
	logic [10:0]        xbig_s1;
	logic [5:0]         d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1 <= in_carry;
			msgn_s1  <= a[63] ^ b[63];
			mx_s1    <= mx;
			pp11_s1  <= pp11;
			pp10_s1  <= pp10;
			pp01_s1  <= pp01;
			pp00_s1  <= pp00;
			asb_s1   <= big[63];
			ass_s1   <= sml[63];
			mbig_s1  <= {big[62:52] != 11'd0, big[51:0]};
			msm_s1   <= {sml[62:52] != 11'd0, sml[51:0]};
			xbig_s1  <= xbig;
			d_s1     <= (dd > 11'd63) ? 6'd63 : dd[5:0];
		end
	end

	// Stage 2: sum the partial products, or align and add with a sticky bit.
	logic [105:0] prod;
	logic [55:0]  aa, b0, bsh;
	logic         astk;
	logic [56:0]  sum;

	assign prod = (106'(pp11_s1) << 54) + (106'(pp10_s1) << 27)
		+ (106'(pp01_s1) << 27) + 106'(pp00_s1);
	assign aa   = {mbig_s1, 3'b000};
	assign b0   = {msm_s1, 3'b000};
	assign bsh  = b0 >> d_s1;
	assign astk = |(b0 & ~({56{1'b1}} << d_s1));
	assign sum  = (asb_s1 != ass_s1) ? (57'(aa) - 57'({bsh[55:1], bsh[0] | astk}))
		: (57'(aa) + 57'({bsh[55:1], bsh[0] | astk}));

	logic               vld_s2;
	carry_t             carry_s2;
	logic               sgn_s2;
	logic [105:0]       m_s2;
	logic signed [13:0] x_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s2 <= carry_s1;
			if (kind == FOP_MUL) begin
				sgn_s2 <= msgn_s1;
				m_s2   <= prod;
				x_s2   <= mx_s1;
			end else begin
				sgn_s2 <= (sum == 57'd0) ? (asb_s1 & ass_s1) : asb_s1;
				m_s2   <= 106'(sum);
				x_s2   <= $signed(14'(xbig_s1)) - 14'sd1078;
			end
		end
	end

	// Stage 3: leading one search, result exponent and shift amount.
	logic [6:0]         msb;
	logic signed [13:0] be, r1, r2, rr, sv;

	always_comb begin
		msb = 7'd0;
		for (int j = 0; j < 106; j++) begin
			if (m_s2[j]) begin
				msb = 7'(j);
			end
		end
	end

	assign be = x_s2 + $signed(14'(msb)) + 14'sd1023;
	assign r1 = $signed(14'(msb)) - 14'sd52;
	assign r2 = -14'sd1074 - x_s2;
	assign rr = (r2 > r1) ? r2 : r1;
	assign sv = rr + 14'sd52;

	logic         vld_s3;
	carry_t       carry_s3;
	logic         sgn_s3, nz_s3;
	logic [105:0] m_s3;
	logic [7:0]   sh_s3;
	logic [10:0]  base_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s3 <= carry_s2;
			sgn_s3   <= sgn_s2;
			nz_s3    <= |m_s2;
			m_s3     <= m_s2;
			sh_s3    <= (sv < 14'sd0) ? 8'd0 : ((sv > 14'sd160) ? 8'd160 : sv[7:0]);
			base_s3  <= (be < 14'sd1) ? 11'd0 : 11'(be - 14'sd1);
		end
	end

	// Stage 4: shift into place, round to nearest even, pack.
	logic [159:0] mxt, yv;
	logic         rstk, inc;
	logic [53:0]  q;
	logic [62:0]  mag;

	assign mxt  = {m_s3, 54'd0};
	assign yv   = mxt >> sh_s3;
	assign rstk = (|(mxt & ~({160{1'b1}} << sh_s3))) | yv[0];
	assign inc  = yv[1] & (rstk | yv[2]);
	assign q    = 54'(yv[54:2]) + 54'(inc);
	assign mag  = {base_s3, 52'd0} + 63'(q);

	logic        vld_s4;
	carry_t      carry_s4;
	logic [63:0] y_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s4 <= carry_s3;
			y_s4     <= nz_s3 ? {sgn_s3, mag} : {sgn_s3, 63'd0};
		end
	end

	assign out_vld   = vld_s4;
	assign out_carry = carry_s4;
	assign y         = y_s4;

endmodule

`default_nettype wire

### design/double_cosine_poly_top.sv
// ----------------------------------------------------------------------------
// double_cosine_poly_top
// Streaming double precision cosine by range reduction and a sine polynomial.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, x_bits) carries one IEEE double per
// transfer. The output channel (out_valid, out_ready, cos_bits,
// out_of_range) returns one result per input, in order.
// The datapath is a chain of 29 floating point operations, each a four-stage
// multiply or add unit; each result is then written into the output queue.
// A new value may be taken in every cycle; the throughput is one result per
// cycle as long as the receiver keeps out_ready high.
// Results land in a two-entry output queue. When it is full the whole
// pipeline freezes and in_ready drops; nothing in flight is lost or repeated.
// Inputs whose magnitude lies above 2^23, infinities and NaNs come out with
// out_of_range set and cos_bits zero; software must handle those.
// Reset empties the pipeline and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "double_cosine_poly_top_defines.svh"

module double_cosine_poly_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] x_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cos_bits,
	output logic        out_of_range
);
	import dcp_pkg::*;

	// Global pipeline enable: every stage advances together while the output
	// queue has room, so bubbles and items keep their relative order.
	logic   en;
	logic   vld_pipe [NOPS+1];
	carry_t carry_pipe [NOPS+1];
	logic [63:0] mag_in;

	assign mag_in = x_bits & MAG_MASK;

	always_comb begin
		carry_pipe[0]     = '0;
		carry_pipe[0].ax  = mag_in;
		carry_pipe[0].oor = mag_in > LIMIT_BITS;
	end
	assign vld_pipe[0] = in_valid;

	// Each slot reads its operands from the carried values, runs one IEEE
	// operation and writes the result back into the carried set.
	for (genvar i = 0; i < NOPS; i++) begin : g_op
		localparam op_desc_t D = op_desc(i);
		logic [63:0] opa, opb, res;
		carry_t      cout;

		assign opa = pick(carry_pipe[i], D.sa, D.cval);
		assign opb = pick(carry_pipe[i], D.sb, D.cval);

		dcp_fop u_fop (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.kind      (D.kind),
			.in_vld    (vld_pipe[i]),
			.in_carry  (carry_pipe[i]),
			.a         (opa),
			.b         (opb),
			.out_vld   (vld_pipe[i+1]),
			.out_carry (cout),
			.y         (res)
		);

		assign carry_pipe[i+1] = put(cout, D, res);
	end

	// Final sign flip for odd N, and the zero result for out of range input.
	result_t fin;
	assign fin.oor = carry_pipe[NOPS].oor;
	assign fin.cos = carry_pipe[NOPS].oor ? 64'd0
		: (carry_pipe[NOPS].acc ^ {carry_pipe[NOPS].kbit, 63'd0});

	// Two-entry output queue decouples the stalled receiver from the pipe.
	result_t    ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign en       = (cnt_q != 2'd2);
	assign in_ready = en;
	assign push     = en & vld_pipe[NOPS];
	assign pop      = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= fin;
		end
	end

	assign out_valid    = (cnt_q != 2'd0);
	assign cos_bits     = ent_q[rd_q].cos;
	assign out_of_range = ent_q[rd_q].oor;

	// A flagged result must carry the fixed zero value.
	`DCP_ASSERT_NOW(a_oor_zero, out_valid && out_of_range, cos_bits == 64'd0, "flagged result not zero")
	// A frozen pipeline must not move its last valid bit.
	`DCP_ASSERT_NEXT(a_stall_hold, !in_ready, $stable(vld_pipe[NOPS]), "pipeline moved while stalled")
	// A push without a pop grows the queue by exactly one entry.
	`DCP_ASSERT_NEXT(a_queue_grow, push && !pop, cnt_q == $past(cnt_q) + 2'd1, "queue count slipped")

endmodule

`default_nettype wire
